### hdl/srv_pkg.sv
`default_nettype none
package srv_pkg;

  localparam int ADDR_W     = 8;
  localparam int DATA_W     = 24;
  localparam int HALF_W     = 10;
  localparam int GAP_W      = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // request codes
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_GAP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ECHO_RD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ECHO_WR     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RD      = 3'd4;

  // configuration register reset values
  localparam logic [HALF_W-1:0] HALF_PERIOD_RST = 10'd8;
  localparam logic [GAP_W-1:0]  RETRY_GAP_RST   = 20'd1000000;
  localparam logic [ADDR_W-1:0] ECHO_RD_RST     = 8'd40;
  localparam logic [ADDR_W-1:0] ECHO_WR_RST     = 8'd45;
  localparam logic [ADDR_W-1:0] MAX_RD_RST      = 8'd127;

  // sequencer phases, one-hot
  typedef enum logic [7:0] {
    PH_IDLE = 8'b0000_0001,
    PH_HI1  = 8'b0000_0010,
    PH_LO1  = 8'b0000_0100,
    PH_GAP1 = 8'b0000_1000,
    PH_HI2  = 8'b0001_0000,
    PH_LO2  = 8'b0010_0000,
    PH_GAP2 = 8'b0100_0000,
    PH_WAIT = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [HALF_W-1:0] half_period;
    logic [GAP_W-1:0]  retry_gap;
    logic [ADDR_W-1:0] echo_rd_addr;
    logic [ADDR_W-1:0] echo_wr_addr;
    logic [ADDR_W-1:0] max_rd_addr;
  } cfg_t;

  typedef struct packed {
    logic              cs_n;
    logic              sclk;
    logic              mosi;
    logic              busy_res;
    logic              done_res;
    logic              ok;
    logic [DATA_W-1:0] rd_data;
    logic              rd_error;
    logic              wr_error;
  } res_t;

endpackage
`default_nettype wire

### hdl/spi_reg_access_with_verify.sv
// SPI master with verified register access for a metering chip.
// Each input item is one bus tick: op (0 tick, 1 verified read, 2 verified
// write), reg_addr, wr_data and the sampled miso level. Each accepted item
// yields exactly one result item with the cs_n, sclk and mosi levels after
// that tick, busy, a one-tick done pulse with ok and rd_data, and the sticky
// rd_error and wr_error flags.
// Each result is held in the result register, or in the skid register while
// the receiver stalls. Throughput: one item per cycle while in_stall is low;
// the whole tick update is a single pass of logic between the sequencer state
// registers and the result register. The two-entry output stage decouples
// the sides: while the receiver stalls, one more item is still taken, then
// in_stall is high until the skid entry moves on. Configuration is written by
// the user via cfg_we/cfg_index/cfg_data only while idle; this is unchecked.
// Reset (rst_n low, synchronous) returns the sequencer to idle, clears both
// error flags, restores the configuration defaults and empties the output.
`default_nettype none
module spi_reg_access_with_verify import srv_pkg::*; #(
  parameter int MAX_ATTEMPTS = 3,
  parameter int DATA_BITS    = 24
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            in_op,
  input  wire logic [ADDR_W-1:0]     in_reg_addr,
  input  wire logic [DATA_W-1:0]     in_wr_data,
  input  wire logic                  in_miso,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_cs_n,
  output logic                       out_sclk,
  output logic                       out_mosi,
  output logic                       out_busy_res,
  output logic                       out_done_res,
  output logic                       out_ok,
  output logic [DATA_W-1:0]          out_rd_data,
  output logic                       out_rd_error,
  output logic                       out_wr_error,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t  cfg_r;
  res_t  res;
  res_t  out_r, skid_r;
  logic  out_valid_r, skid_valid_r;
  logic  in_acc, out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_period  <= HALF_PERIOD_RST;
      cfg_r.retry_gap    <= RETRY_GAP_RST;
      cfg_r.echo_rd_addr <= ECHO_RD_RST;
      cfg_r.echo_wr_addr <= ECHO_WR_RST;
      cfg_r.max_rd_addr  <= MAX_RD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HALF_PERIOD: cfg_r.half_period  <= cfg_data[HALF_W-1:0];
        CFG_RETRY_GAP:   cfg_r.retry_gap    <= cfg_data[GAP_W-1:0];
        CFG_ECHO_RD:     cfg_r.echo_rd_addr <= cfg_data[ADDR_W-1:0];
        CFG_ECHO_WR:     cfg_r.echo_wr_addr <= cfg_data[ADDR_W-1:0];
        CFG_MAX_RD:      cfg_r.max_rd_addr  <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !skid_valid_r;
  assign out_free = !out_valid_r || !out_stall;

  srv_seq #(
    .MAX_ATTEMPTS (MAX_ATTEMPTS),
    .DATA_BITS    (DATA_BITS)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (in_acc),
    .cfg      (cfg_r),
    .op       (in_op),
    .reg_addr (in_reg_addr),
    .wr_data  (in_wr_data),
    .miso     (in_miso),
    .res      (res)
  );

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) out_r <= skid_r;
      else if (in_acc)  out_r <= res;
    end else if (in_acc) begin
      skid_r <= res;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_cs_n     = out_r.cs_n;
  assign out_sclk     = out_r.sclk;
  assign out_mosi     = out_r.mosi;
  assign out_busy_res = out_r.busy_res;
  assign out_done_res = out_r.done_res;
  assign out_ok       = out_r.ok;
  assign out_rd_data  = out_r.rd_data;
  assign out_rd_error = out_r.rd_error;
  assign out_wr_error = out_r.wr_error;

endmodule
`default_nettype wire

### hdl/srv_seq.sv
`default_nettype none
module srv_seq import srv_pkg::*; #(
  parameter int MAX_ATTEMPTS = 3,
  parameter int DATA_BITS    = 24
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire cfg_t              cfg,
  input  wire logic [1:0]        op,
  input  wire logic [ADDR_W-1:0] reg_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              miso,
  output res_t                   res
);

  localparam int                LAST_BIT  = 7 + DATA_BITS;
  localparam int                PAD_SHIFT = DATA_W - DATA_BITS;
  localparam logic [4:0]        LAST_BIT_C = 5'(LAST_BIT);
  localparam logic [2:0]        MAX_ATT_C  = 3'(MAX_ATTEMPTS);

  phase_t                 phase_r, phase_nxt;
  logic [4:0]             bit_r, bit_nxt;
  logic [GAP_W-1:0]       tick_r, tick_nxt;
  logic [31:0]            sout_r, sout_nxt;
  logic [DATA_BITS-1:0]   sin_r, sin_nxt;
  logic [DATA_BITS-1:0]   first_r, first_nxt;
  logic [1:0]             att_r, att_nxt;
  logic [1:0]             rop_r, rop_nxt;
  logic [ADDR_W-1:0]      raddr_r, raddr_nxt;
  logic [DATA_W-1:0]      rdata_r, rdata_nxt;
  logic                   rd_err_r, rd_err_nxt;
  logic                   wr_err_r, wr_err_nxt;

  logic [HALF_W-1:0]      half_len;
  logic                   half_end;
  logic                   gap_end;
  logic                   is_wr;
  logic                   load, load_primary;
  phase_t                 load_phase;
  logic [ADDR_W-1:0]      load_addr;
  logic [DATA_W-1:0]      load_data;
  logic                   done, okv;
  logic [DATA_BITS-1:0]   rdv;
  logic                   framing;

  // a zero half period behaves as one tick
  assign half_len = (cfg.half_period == '0) ? HALF_W'(1) : cfg.half_period;
  assign half_end = ({1'b0, tick_r} + 21'd1) >= {11'b0, half_len};
  assign gap_end  = ({1'b0, tick_r} + 21'd1) >= {1'b0, cfg.retry_gap};
  assign is_wr    = (rop_r == OP_WRITE);

  // next-state logic for one tick
  always_comb begin
    phase_nxt    = phase_r;
    bit_nxt      = bit_r;
    tick_nxt     = tick_r;
    sout_nxt     = sout_r;
    sin_nxt      = sin_r;
    first_nxt    = first_r;
    att_nxt      = att_r;
    rop_nxt      = rop_r;
    raddr_nxt    = raddr_r;
    rdata_nxt    = rdata_r;
    rd_err_nxt   = rd_err_r;
    wr_err_nxt   = wr_err_r;
    load         = 1'b0;
    load_primary = 1'b0;
    load_phase   = PH_HI2;
    load_addr    = is_wr ? cfg.echo_wr_addr : cfg.echo_rd_addr;
    done         = 1'b0;
    okv          = 1'b0;
    rdv          = '0;

    case (phase_r)
      PH_IDLE: begin
        if (op == OP_READ || op == OP_WRITE) begin
          if (op == OP_READ && reg_addr > cfg.max_rd_addr) begin
            done = 1'b1;
          end else begin
            rop_nxt      = op;
            raddr_nxt    = reg_addr;
            rdata_nxt    = wr_data;
            att_nxt      = 2'd0;
            load_primary = 1'b1;
          end
        end
      end
      PH_HI1, PH_HI2: begin
        if (half_end) begin
          if (bit_r >= 5'd8) sin_nxt = {sin_r[DATA_BITS-2:0], miso};
          phase_nxt = (phase_r == PH_HI1) ? PH_LO1 : PH_LO2;
          tick_nxt  = '0;
        end else begin
          tick_nxt = tick_r + 1'b1;
        end
      end
      PH_LO1, PH_LO2: begin
        if (!half_end) begin
          tick_nxt = tick_r + 1'b1;
        end else begin
          tick_nxt = '0;
          if (bit_r >= LAST_BIT_C) begin
            // end of frame
            if (phase_r == PH_LO1) begin
              first_nxt = sin_r;
              phase_nxt = PH_GAP1;
            end else if (sin_r == (is_wr ? rdata_r[DATA_BITS-1:0] : first_r)) begin
              done      = 1'b1;
              okv       = 1'b1;
              rdv       = is_wr ? '0 : first_r;
              phase_nxt = PH_IDLE;
            end else if (({1'b0, att_r} + 3'd1) >= MAX_ATT_C) begin
              done = 1'b1;
              if (is_wr) wr_err_nxt = 1'b1;
              else       rd_err_nxt = 1'b1;
              phase_nxt = PH_IDLE;
            end else begin
              att_nxt   = att_r + 2'd1;
              phase_nxt = PH_GAP2;
            end
          end else begin
            bit_nxt   = bit_r + 5'd1;
            sout_nxt  = {sout_r[30:0], 1'b0};
            phase_nxt = (phase_r == PH_LO1) ? PH_HI1 : PH_HI2;
          end
        end
      end
      PH_GAP1: begin
        if (half_end) load = 1'b1;
        else          tick_nxt = tick_r + 1'b1;
      end
      PH_GAP2: begin
        if (half_end) begin
          tick_nxt = '0;
          if (!is_wr && cfg.retry_gap != '0) phase_nxt = PH_WAIT;
          else                                load_primary = 1'b1;
        end else begin
          tick_nxt = tick_r + 1'b1;
        end
      end
      PH_WAIT: begin
        if (gap_end) load_primary = 1'b1;
        else         tick_nxt = tick_r + 1'b1;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase

    // frame start: primary access or echo read
    if (load_primary) begin
      load       = 1'b1;
      load_phase = PH_HI1;
      load_addr  = raddr_nxt;
    end
    load_data = (load_primary && rop_nxt == OP_WRITE) ?
                (DATA_W'(rdata_nxt[DATA_BITS-1:0]) << PAD_SHIFT) : '0;
    if (load) begin
      phase_nxt = load_phase;
      bit_nxt   = '0;
      tick_nxt  = '0;
      sin_nxt   = '0;
      sout_nxt  = {load_addr, load_data};
    end
  end

  // state registers, advance on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      bit_r    <= '0;
      tick_r   <= '0;
      att_r    <= '0;
      rd_err_r <= 1'b0;
      wr_err_r <= 1'b0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      bit_r    <= bit_nxt;
      tick_r   <= tick_nxt;
      att_r    <= att_nxt;
      rd_err_r <= rd_err_nxt;
      wr_err_r <= wr_err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      sout_r  <= sout_nxt;
      sin_r   <= sin_nxt;
      first_r <= first_nxt;
      rop_r   <= rop_nxt;
      raddr_r <= raddr_nxt;
      rdata_r <= rdata_nxt;
    end
  end

  // result levels after this tick
  assign framing = (phase_nxt == PH_HI1) || (phase_nxt == PH_LO1) ||
                   (phase_nxt == PH_HI2) || (phase_nxt == PH_LO2);

  always_comb begin
    res.cs_n     = !framing;
    res.sclk     = (phase_nxt == PH_HI1) || (phase_nxt == PH_HI2);
    res.mosi     = framing & sout_nxt[31];
    res.busy_res = (phase_nxt != PH_IDLE);
    res.done_res = done;
    res.ok       = okv;
    res.rd_data  = DATA_W'(rdv);
    res.rd_error = rd_err_nxt;
    res.wr_error = wr_err_nxt;
  end

endmodule
`default_nettype wire

### test/spi_reg_access_with_verify_tb.sv
`default_nettype none
module spi_reg_access_with_verify_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import srv_pkg::*;

  localparam int TRIES = 3;
  // request codes that start nothing
  localparam logic [1:0] OP_NONE   = 2'd0;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Bus tick model: mirrors the sequencer and queues the levels each tick should show
  class tick_predictor;
    logic [HALF_W-1:0] half_per;
    logic [GAP_W-1:0]  retry_gap;
    logic [ADDR_W-1:0] echo_rd, echo_wr, max_rd;
    phase_t            phase;
    logic [4:0]        bit_cnt;
    logic [19:0]       tick_cnt;
    logic [31:0]       sh_out;
    logic [23:0]       sh_in, first_val;
    logic [1:0]        attempt;
    logic [1:0]        req_op;
    logic [7:0]        req_addr;
    logic [23:0]       req_data;
    logic [1:0]        err_flags;
    res_t              level_q[$];
    int                errors, n_ticks, n_checked, n_verified, n_failed;

    function new();
      half_per  = HALF_PERIOD_RST;
      retry_gap = RETRY_GAP_RST;
      echo_rd   = ECHO_RD_RST;
      echo_wr   = ECHO_WR_RST;
      max_rd    = MAX_RD_RST;
      phase     = PH_IDLE;
      bit_cnt   = '0;
      tick_cnt  = '0;
      sh_out    = '0;
      sh_in     = '0;
      first_val = '0;
      attempt   = '0;
      req_op    = '0;
      req_addr  = '0;
      req_data  = '0;
      err_flags = '0;
      errors = 0; n_ticks = 0; n_checked = 0; n_verified = 0; n_failed = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        CFG_HALF_PERIOD: half_per  = v[HALF_W-1:0];
        CFG_RETRY_GAP:   retry_gap = v[GAP_W-1:0];
        CFG_ECHO_RD:     echo_rd   = v[ADDR_W-1:0];
        CFG_ECHO_WR:     echo_wr   = v[ADDR_W-1:0];
        CFG_MAX_RD:      max_rd    = v[ADDR_W-1:0];
        default: ;
      endcase
    endfunction

    // last tick of a half period; zero counts as one tick
    function bit half_done();
      int unsigned len;
      len = (half_per == '0) ? 1 : half_per;
      return (tick_cnt + 32'd1) >= len;
    endfunction

    function void start_frame(phase_t hi, logic [7:0] a, logic [23:0] d);
      phase    = hi;
      bit_cnt  = '0;
      tick_cnt = '0;
      sh_in    = '0;
      sh_out   = {a, d};
    endfunction

    function void start_primary();
      start_frame(PH_HI1, req_addr, (req_op == OP_WRITE) ? req_data : 24'd0);
    endfunction

    // one tick of a bit; true on the tick that closes the frame
    function bit bit_tick(logic miso, phase_t hi, phase_t lo);
      bit at_end;
      at_end = half_done();
      if (phase != lo) begin
        if (at_end) begin
          if (bit_cnt >= 5'd8) sh_in = {sh_in[22:0], miso};
          phase    = lo;
          tick_cnt = '0;
        end else begin
          tick_cnt++;
        end
        return 1'b0;
      end
      if (!at_end) begin
        tick_cnt++;
        return 1'b0;
      end
      tick_cnt = '0;
      if (bit_cnt >= 5'd31) return 1'b1;
      bit_cnt++;
      sh_out = sh_out << 1;
      phase  = hi;
      return 1'b0;
    endfunction

    function void take_tick(logic [1:0] op, logic [7:0] addr, logic [23:0] wd, logic miso);
      res_t        e;
      logic        done, okv, is_wr, framing;
      logic [23:0] rdv, want;
      done = 1'b0;
      okv  = 1'b0;
      rdv  = '0;
      n_ticks++;
      case (phase)
        PH_IDLE: begin
          if (op == OP_READ || op == OP_WRITE) begin
            // out-of-range read is refused at once, no frame, no flag
            if (op == OP_READ && addr > max_rd) begin
              done = 1'b1;
            end else begin
              req_op   = op;
              req_addr = addr;
              req_data = wd;
              attempt  = '0;
              start_primary();
            end
          end
        end
        PH_HI1, PH_LO1: begin
          if (bit_tick(miso, PH_HI1, PH_LO1)) begin
            first_val = sh_in;
            phase     = PH_GAP1;
          end
        end
        PH_GAP1: begin
          if (half_done())
            start_frame(PH_HI2, (req_op == OP_WRITE) ? echo_wr : echo_rd, 24'd0);
          else
            tick_cnt++;
        end
        PH_HI2, PH_LO2: begin
          if (bit_tick(miso, PH_HI2, PH_LO2)) begin
            is_wr = (req_op == OP_WRITE);
            want  = is_wr ? req_data : first_val;
            if (sh_in == want) begin
              done  = 1'b1;
              okv   = 1'b1;
              rdv   = is_wr ? 24'd0 : first_val;
              phase = PH_IDLE;
            end else if (attempt + 32'd1 >= TRIES) begin
              done      = 1'b1;
              err_flags = err_flags | (is_wr ? 2'b10 : 2'b01);
              phase     = PH_IDLE;
            end else begin
              attempt++;
              phase = PH_GAP2;
            end
          end
        end
        PH_GAP2: begin
          if (half_done()) begin
            tick_cnt = '0;
            // reads wait out the retry gap, writes retry at once
            if (req_op != OP_WRITE && retry_gap != '0) phase = PH_WAIT;
            else start_primary();
          end else begin
            tick_cnt++;
          end
        end
        PH_WAIT: begin
          if (tick_cnt + 32'd1 >= retry_gap) start_primary();
          else tick_cnt++;
        end
        default: phase = PH_IDLE;
      endcase

      framing = (phase == PH_HI1) || (phase == PH_LO1) || (phase == PH_HI2) || (phase == PH_LO2);
      e.cs_n     = ~framing;
      e.sclk     = (phase == PH_HI1) || (phase == PH_HI2);
      e.mosi     = framing & sh_out[31];
      e.busy_res = (phase != PH_IDLE);
      e.done_res = done;
      e.ok       = okv;
      e.rd_data  = rdv;
      e.rd_error = err_flags[0];
      e.wr_error = err_flags[1];
      if (done && okv) n_verified++;
      if (done && !okv) n_failed++;
      level_q.push_back(e);
    endfunction

    function void field_check(string name, logic [23:0] e, logic [23:0] a);
      if (e !== a) begin
        $error("%s: expected %0h, got %0h", name, e, a);
        errors++;
      end
    endfunction

    function void compare_levels(res_t act);
      res_t e;
      if (level_q.size() == 0) begin
        $error("result item with no expected levels waiting");
        errors++;
        return;
      end
      e = level_q.pop_front();
      n_checked++;
      field_check("cs_n", e.cs_n, act.cs_n);
      field_check("sclk", e.sclk, act.sclk);
      field_check("mosi", e.mosi, act.mosi);
      field_check("busy_res", e.busy_res, act.busy_res);
      field_check("done_res", e.done_res, act.done_res);
      field_check("ok", e.ok, act.ok);
      field_check("rd_data", e.rd_data, act.rd_data);
      field_check("rd_error", e.rd_error, act.rd_error);
      field_check("wr_error", e.wr_error, act.wr_error);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            in_op;
  logic [ADDR_W-1:0]     in_reg_addr;
  logic [DATA_W-1:0]     in_wr_data;
  logic                  in_miso;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_cs_n, out_sclk, out_mosi, out_busy_res, out_done_res, out_ok;
  logic [DATA_W-1:0]     out_rd_data;
  logic                  out_rd_error, out_wr_error;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tick_predictor sb = new();

  // stimulus knobs and the chip's planned answers
  bit          sender_idles = 1'b1;
  bit          rcv_idles    = 1'b1;
  int          bad_tries    = 0;
  logic [23:0] plan_first   = '0;
  logic [23:0] plan_echo    = '0;

  spi_reg_access_with_verify DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_reg_addr  (in_reg_addr),
    .in_wr_data   (in_wr_data),
    .in_miso      (in_miso),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_cs_n     (out_cs_n),
    .out_sclk     (out_sclk),
    .out_mosi     (out_mosi),
    .out_busy_res (out_busy_res),
    .out_done_res (out_done_res),
    .out_ok       (out_ok),
    .out_rd_data  (out_rd_data),
    .out_rd_error (out_rd_error),
    .out_wr_error (out_wr_error),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #400_000;
    $display("Test completed with failures");
    $finish;
  end

  // receiver stall bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rcv_idles && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    res_t act;
    if (rst_n && out_valid && !out_stall) begin
      act.cs_n     = out_cs_n;
      act.sclk     = out_sclk;
      act.mosi     = out_mosi;
      act.busy_res = out_busy_res;
      act.done_res = out_done_res;
      act.ok       = out_ok;
      act.rd_data  = out_rd_data;
      act.rd_error = out_rd_error;
      act.wr_error = out_wr_error;
      sb.compare_levels(act);
    end
  end

  // chip side: answer the sampled data bits from the plan, random elsewhere
  function logic pick_miso();
    logic [23:0] want;
    logic        b;
    b = 1'($urandom);
    case (sb.phase)
      PH_IDLE, PH_GAP2, PH_WAIT: begin
        case ($urandom_range(0, 5))
          0: plan_first = '0;
          1: plan_first = '1;
          default: plan_first = 24'($urandom);
        endcase
      end
      PH_GAP1: begin
        // the echo is wrong on the first bad_tries attempts of an access
        want = (sb.req_op == OP_WRITE) ? sb.req_data : sb.first_val;
        if (int'(sb.attempt) < bad_tries)
          plan_echo = want ^ 24'($urandom_range(1, 24'hFFFFFF));
        else
          plan_echo = want;
      end
      PH_HI1: if (sb.bit_cnt >= 5'd8) b = plan_first[5'd31 - sb.bit_cnt];
      PH_HI2: if (sb.bit_cnt >= 5'd8) b = plan_echo[5'd31 - sb.bit_cnt];
      default: ;
    endcase
    return b;
  endfunction

  function logic [7:0] pick_addr();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return sb.max_rd;
      3: return sb.max_rd + 8'd1;
      default: return 8'($urandom);
    endcase
  endfunction

  function logic [23:0] pick_data();
    case ($urandom_range(0, 9))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  // drive one item and hold it until taken
  task send(input logic [1:0] op, input logic [7:0] a, input logic [23:0] d, input logic m);
    if (sender_idles && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_reg_addr <= a;
    in_wr_data  <= d;
    in_miso     <= m;
    do @(posedge clk); while (in_stall);
    sb.take_tick(op, a, d, m);
  endtask

  task tick(input logic [1:0] op, input logic [7:0] a, input logic [23:0] d);
    logic m;
    m = pick_miso();
    send(op, a, d, m);
  endtask

  // one request, then ticks with ignored ops until the sequencer is idle
  task access(input logic [1:0] op, input logic [7:0] a, input logic [23:0] d);
    tick(op, a, d);
    while (sb.phase != PH_IDLE) tick(2'($urandom_range(0, 3)), pick_addr(), pick_data());
  endtask

  // stop sending until every result is back
  task hold_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.level_q.size() != 0);
  endtask

  // bring the sequencer to idle and drain the output side
  task settle();
    while (sb.phase != PH_IDLE) tick(OP_NONE, pick_addr(), pick_data());
    hold_for_results();
    repeat (4) @(posedge clk);
  endtask

  task load_regs(input logic [CFG_DATA_W-1:0] half, input logic [CFG_DATA_W-1:0] gap,
                 input logic [CFG_DATA_W-1:0] erd, input logic [CFG_DATA_W-1:0] ewr,
                 input logic [CFG_DATA_W-1:0] mx);
    cfg_we <= 1'b1;
    cfg_index <= CFG_HALF_PERIOD; cfg_data <= half; @(posedge clk);
    sb.set_reg(CFG_HALF_PERIOD, half);
    cfg_index <= CFG_RETRY_GAP;   cfg_data <= gap;  @(posedge clk);
    sb.set_reg(CFG_RETRY_GAP, gap);
    cfg_index <= CFG_ECHO_RD;     cfg_data <= erd;  @(posedge clk);
    sb.set_reg(CFG_ECHO_RD, erd);
    cfg_index <= CFG_ECHO_WR;     cfg_data <= ewr;  @(posedge clk);
    sb.set_reg(CFG_ECHO_WR, ewr);
    cfg_index <= CFG_MAX_RD;      cfg_data <= mx;   @(posedge clk);
    sb.set_reg(CFG_MAX_RD, mx);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_op       = OP_NONE;
    in_reg_addr = '0;
    in_wr_data  = '0;
    in_miso     = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_HALF_PERIOD;
    cfg_data    = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: plain ticks and refused reads, frames here are long
    tick(OP_NONE, 8'hFF, 24'hFFFFFF);
    tick(OP_UNUSED, 8'h00, 24'h000000);
    access(OP_READ, MAX_RD_RST + 8'd1, 24'h000000);
    access(OP_READ, 8'hFF, 24'h000000);
    settle();

    // shortest bit time, no retry gap: first echo wrong, write retried at once
    load_regs(20'd1, 20'd0, 20'hFFF00, 20'h000FF, 20'h000FF);
    bad_tries = 1;
    access(OP_WRITE, 8'h5A, 24'hA5A5A5);
    settle();

    // zero half period, short gap, only address zero readable
    load_regs(20'hFFC00, 20'd3, 20'h000FF, 20'hABC00, 20'h00000);
    access(OP_READ, 8'h01, 24'h000000);
    // echo never matches: three read tries, sticky read error
    bad_tries = 3;
    access(OP_READ, 8'h00, pick_data());
    settle();

    // closing stretch without idling on either side
    sender_idles = 1'b0;
    rcv_idles    = 1'b0;
    bad_tries    = 0;
    access(OP_READ, 8'h00, pick_data());
    settle();

    repeat (2000) if (sb.level_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.level_q.size() != 0) begin
      $error("%0d expected result items never arrived", sb.level_q.size());
      sb.errors++;
    end

    $display("Ran %0d bus ticks under three register settings, %0d result items checked.",
             sb.n_ticks, sb.n_checked);
    $display("Accesses verified: %0d, failed or refused: %0d.", sb.n_verified, sb.n_failed);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
